/* sv/gdbrsp_pkg.sv */
// Package for the remote-debugger packet checker: character codes, phase
// and verdict encodings, result record and hex digit decode.
// No dependencies.
`timescale 1ns / 1ps

package gdbrsp_pkg;

    // Sizes of the packet state
    localparam int unsigned MAX_PACKET_DEFAULT = 1024;
    localparam int unsigned LEN_W              = 11;
    localparam int unsigned TICK_W             = 16;

    // Framing characters
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_HASH   = 8'h23;

    // Saturation point of the idle tick counter
    localparam logic [TICK_W-1:0] C_IDLE_SAT = 16'hFFFF;

    // Reset value of the timeout register
    localparam logic [TICK_W-1:0] C_TIMEOUT_RESET = 16'd100;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_HEX1 = 2'd2,
        PH_HEX2 = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        V_INPKT   = 3'd0,
        V_GOOD    = 3'd1,
        V_BAD     = 3'd2,
        V_OVER    = 3'd3,
        V_TIMEOUT = 3'd4,
        V_OUTSIDE = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       has_byte;
        t_verdict   verdict;
        logic       packet_end;
    } t_result;

    // Decode one hex character; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        case (c) inside
            [8'h30:8'h39]: v = c[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: v = c[3:0] + 4'd9;
            default:       v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/gdbrsp_ifs.sv */
// Handshake channels of the packet checker: input beats, result beats and
// the configuration write channel. No dependencies.
`timescale 1ns / 1ps

interface gdbrsp_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] byte_in;

    modport source (output valid, operation, byte_in, input ready);
    modport sink   (input valid, operation, byte_in, output ready);
endinterface

interface gdbrsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       has_byte;
    logic [2:0] verdict;
    logic       packet_end;

    modport source (output valid, byte_out, has_byte, verdict, packet_end, input ready);
    modport sink   (input valid, byte_out, has_byte, verdict, packet_end, output ready);
endinterface

interface gdbrsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* sv/gdb_rsp_packet_checker.sv */
// Top level of the remote-debugger packet checker.
// Depends on gdbrsp_pkg, gdbrsp_ifs and gdbrsp_parser.
//
// Usage:
//   i_in   : input beats. operation 0 carries a received byte in byte_in,
//            operation 1 is one time tick (byte_in ignored).
//   o_res  : result beats. Every byte beat gives one result: the byte passed
//            through with a verdict (in packet, good, checksum bad, overflow,
//            outside packet) and packet_end on the closing byte. A tick gives
//            a result only when it times out an open packet (byte_out 0,
//            has_byte 0, verdict timeout, packet_end 1).
//   i_cfg  : writes timeout_ticks; always ready. Write only while idle.
// Output: a result appears on o_res in the cycle after its input beat.
// Throughput: one input beat per cycle while o_res is taken every cycle;
//   the parser updates its state once per accepted beat.
// Stall: results sit in one output register. While it holds an untaken
//   result, i_in.ready drops; a beat is still accepted in the same cycle the
//   waiting result is taken.
// Reset: no packet open, all sums and counters zero, timeout_ticks = 100,
//   output register empty.
`timescale 1ns / 1ps

module gdb_rsp_packet_checker
    import gdbrsp_pkg::*;
#(
    parameter int unsigned MAX_PACKET = MAX_PACKET_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gdbrsp_in_if.sink     i_in,
    gdbrsp_out_if.source  o_res,
    gdbrsp_cfg_if.sink    i_cfg
);

    logic [TICK_W-1:0] r_timeout;
    logic              r_out_valid;
    t_result           r_out;

    logic              in_accept;
    logic              emit;
    t_result           result;

    // Accept while the output register is empty or being drained
    assign i_in.ready  = !r_out_valid || o_res.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= C_TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            r_timeout <= i_cfg.data;
        end
    end

    gdbrsp_parser #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_operation (i_in.operation),
        .i_byte      (i_in.byte_in),
        .i_timeout   (r_timeout),
        .o_emit      (emit),
        .o_result    (result)
    );

    // Output register: load a new result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_out <= result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.byte_out   = r_out.byte_out;
    assign o_res.has_byte   = r_out.has_byte;
    assign o_res.verdict    = r_out.verdict;
    assign o_res.packet_end = r_out.packet_end;

endmodule

/* sv/gdbrsp_parser.sv */
// Packet state tracker: phase, sums, length and idle counter, updated once
// per accepted beat, plus the result for that beat. Depends on gdbrsp_pkg.
`timescale 1ns / 1ps

module gdbrsp_parser
    import gdbrsp_pkg::*;
#(
    parameter int unsigned MAX_PACKET = MAX_PACKET_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_operation,
    input  logic [7:0]        i_byte,
    input  logic [TICK_W-1:0] i_timeout,
    output logic              o_emit,
    output t_result           o_result
);

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PACKET);

    t_phase            r_phase,    n_phase;
    logic [7:0]        r_run_sum,  n_run_sum;
    logic [7:0]        r_rcv_sum,  n_rcv_sum;
    logic [LEN_W-1:0]  r_len,      n_len;
    logic [TICK_W-1:0] r_idle,     n_idle;

    logic [TICK_W-1:0] idle_inc;
    logic [7:0]        full_sum;

    // Hold state, then apply the beat
    always_comb begin
        n_phase   = r_phase;
        n_run_sum = r_run_sum;
        n_rcv_sum = r_rcv_sum;
        n_len     = r_len;
        n_idle    = r_idle;
        o_emit    = 1'b0;
        o_result  = '{byte_out: i_byte, has_byte: 1'b1, verdict: V_INPKT, packet_end: 1'b0};
        idle_inc  = (r_idle == C_IDLE_SAT) ? r_idle : r_idle + TICK_W'(1);
        full_sum  = r_rcv_sum | {4'd0, hex_nibble(i_byte)};

        if (i_accept) begin
            if (i_operation == OP_TICK) begin
                // Count idle time inside a packet, drop it on timeout
                if (r_phase != PH_IDLE) begin
                    n_idle = idle_inc;
                    if (idle_inc >= i_timeout) begin
                        n_phase   = PH_IDLE;
                        n_run_sum = '0;
                        n_rcv_sum = '0;
                        n_len     = '0;
                        n_idle    = '0;
                        o_emit    = 1'b1;
                        o_result  = '{byte_out: 8'd0, has_byte: 1'b0,
                                      verdict: V_TIMEOUT, packet_end: 1'b1};
                    end
                end
            end else if (r_phase == PH_IDLE) begin
                // Open a packet on '$', else mark the beat outside
                o_emit = 1'b1;
                if (i_byte == C_DOLLAR) begin
                    n_phase = PH_BODY;
                    n_len   = LEN_W'(1);
                end else begin
                    o_result.verdict = V_OUTSIDE;
                end
            end else begin
                o_emit = 1'b1;
                n_idle = '0;
                if (r_len >= MaxLen) begin
                    // Length limit reached: close as overflow
                    n_phase            = PH_IDLE;
                    n_run_sum          = '0;
                    n_rcv_sum          = '0;
                    n_len              = '0;
                    o_result.verdict    = V_OVER;
                    o_result.packet_end = 1'b1;
                end else begin
                    n_len = r_len + LEN_W'(1);
                    if (i_byte == C_HASH) begin
                        n_phase = PH_HEX1;
                    end else begin
                        case (r_phase)
                            PH_BODY: begin
                                n_run_sum = r_run_sum + i_byte;
                            end
                            PH_HEX1: begin
                                n_rcv_sum = {hex_nibble(i_byte), 4'd0};
                                n_phase   = PH_HEX2;
                            end
                            PH_HEX2: begin
                                // Second digit completes the checksum
                                n_phase             = PH_IDLE;
                                n_run_sum           = '0;
                                n_rcv_sum           = '0;
                                n_len               = '0;
                                o_result.verdict    = (full_sum == r_run_sum) ? V_GOOD : V_BAD;
                                o_result.packet_end = 1'b1;
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_run_sum <= '0;
            r_rcv_sum <= '0;
            r_len     <= '0;
            r_idle    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_run_sum <= n_run_sum;
            r_rcv_sum <= n_rcv_sum;
            r_len     <= n_len;
            r_idle    <= n_idle;
        end
    end

endmodule

/* sv/gdbrsp_checker.sv */
// Port-level checks for the packet checker, bound to the top level.
// Depends on gdbrsp_pkg and gdb_rsp_packet_checker.
`timescale 1ns / 1ps

module gdbrsp_checker
    import gdbrsp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_byte_out,
    input logic       i_has_byte,
    input logic [2:0] i_verdict,
    input logic       i_packet_end
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_byte_out)
            && $stable(i_verdict) && $stable(i_packet_end) && $stable(i_has_byte))
        else $error("stalled result beat changed");

    // Input stalls only behind a waiting result
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

    // A beat without a byte is always a timeout close
    a_timeout_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_byte |->
            i_verdict == V_TIMEOUT && i_packet_end && i_byte_out == 8'd0)
        else $error("byteless result is not a timeout");

    // packet_end marks exactly the closing verdicts
    a_end_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_packet_end == (i_verdict == V_GOOD || i_verdict == V_BAD
            || i_verdict == V_OVER || i_verdict == V_TIMEOUT))
        else $error("packet_end does not match verdict");

endmodule

bind gdb_rsp_packet_checker gdbrsp_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_byte_out   (o_res.byte_out),
    .i_has_byte   (o_res.has_byte),
    .i_verdict    (o_res.verdict),
    .i_packet_end (o_res.packet_end)
);
